// File: rtl/tfn_pkg.sv
// Shared types and codes for the tangent frame pipeline.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps
package tfn_pkg;
	localparam int TAG_W = 16;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// neg[0], neg[1]: signs of the two plain quotients
	// neg[2], neg[3]: signs of the two product quotients
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		axis_t axis;
		logic degen;
		logic [3:0] neg;
	} ctl_t;
endpackage

// File: rtl/tangent_frame_from_normal.sv
// Channel  Direction  Handshake                 Payload
// node     in         node_valid / node_stall   node_tag, normal_x/y/z
// frame    out        frame_valid / frame_stall result_tag, tangents, chosen_axis, degenerate
//
// One request enters per cycle unless a stalled result is held; the pipeline depth is
// set by the square root (one bit per stage) and the divider (one bit per stage).
// Reset clears only the valid bits of every stage.
// A stalled result freezes the whole pipeline, input included, so node_stall follows
// frame_stall while a result is held; nothing is dropped or repeated.
// Uses tfn_pkg, tfn_front, tfn_sqrt, tfn_div.
`timescale 1ns / 1ps
module tangent_frame_from_normal #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic node_valid,
	output logic node_stall,
	input  logic [tfn_pkg::TAG_W-1:0] node_tag,
	input  logic signed [COMPONENT_WIDTH-1:0] normal_x,
	input  logic signed [COMPONENT_WIDTH-1:0] normal_y,
	input  logic signed [COMPONENT_WIDTH-1:0] normal_z,
	output logic frame_valid,
	input  logic frame_stall,
	output logic [tfn_pkg::TAG_W-1:0] result_tag,
	output logic signed [COMPONENT_WIDTH-1:0] first_tangent_x,
	output logic signed [COMPONENT_WIDTH-1:0] first_tangent_y,
	output logic signed [COMPONENT_WIDTH-1:0] first_tangent_z,
	output logic signed [COMPONENT_WIDTH-1:0] second_tangent_x,
	output logic signed [COMPONENT_WIDTH-1:0] second_tangent_y,
	output logic signed [COMPONENT_WIDTH-1:0] second_tangent_z,
	output logic [1:0] chosen_axis,
	output logic degenerate
);
	localparam int W = COMPONENT_WIDTH;
	localparam int CW = $bits(tfn_pkg::ctl_t);
	localparam int SB1 = 8*W + CW;
	localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

	logic en;
	logic f_valid;
	logic [2*W:0] f_s;
	logic [2*W-1:0] f_num [4];
	tfn_pkg::ctl_t f_ctl;

	logic r_valid;
	logic [W-1:0] r_root;
	logic [SB1-1:0] r_sb;
	logic [2*W-1:0] r_num [4];
	tfn_pkg::ctl_t r_ctl;

	logic d_valid;
	logic [3:0] d_ovf;
	logic [W-1:0] d_q [4];
	logic [W-1:0] d_l;
	logic [CW-1:0] d_sb;
	tfn_pkg::ctl_t d_ctl;

	logic [W-1:0] qa, qb, pa, pb, nl;

	logic frame_valid_q;
	logic [tfn_pkg::TAG_W-1:0] tag_q;
	logic [W-1:0] ftx_q, fty_q, ftz_q, stx_q, sty_q, stz_q;
	logic [1:0] axis_q;
	logic degen_q;

	function automatic logic [W-1:0] sat_enc(input logic neg, input logic big,
		input logic [W-1:0] mag);
		if (neg) begin
			return (big || mag > HALF) ? HALF : (~mag + W'(1));
		end
		return (big || mag >= HALF) ? (HALF - W'(1)) : mag;
	endfunction

	assign en = !(frame_valid_q && frame_stall);
	assign node_stall = !en;

	tfn_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(node_valid),
		.tag(node_tag), .nx(normal_x), .ny(normal_y), .nz(normal_z),
		.out_valid(f_valid), .s_sel(f_s), .num(f_num), .ctl(f_ctl)
	);

	tfn_sqrt #(.W(W), .SB(SB1)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(f_valid), .s(f_s),
		.sb_in({f_num[0], f_num[1], f_num[2], f_num[3], f_ctl}),
		.out_valid(r_valid), .root(r_root), .sb_out(r_sb)
	);

	assign {r_num[0], r_num[1], r_num[2], r_num[3], r_ctl} = r_sb;

	tfn_div #(.W(W), .SB(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(r_valid), .num(r_num),
		.l_in(r_root), .sb_in(r_ctl), .out_valid(d_valid), .ovf(d_ovf), .q(d_q),
		.l_out(d_l), .sb_out(d_sb)
	);

	assign d_ctl = tfn_pkg::ctl_t'(d_sb);
	assign qa = sat_enc(d_ctl.neg[0], d_ovf[0], d_q[0]);
	assign qb = sat_enc(d_ctl.neg[1], d_ovf[1], d_q[1]);
	assign pa = sat_enc(d_ctl.neg[2], d_ovf[2], d_q[2]);
	assign pb = sat_enc(d_ctl.neg[3], d_ovf[3], d_q[3]);
	assign nl = sat_enc(1'b1, 1'b0, d_l);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (en) begin
			frame_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= d_ctl.tag;
			degen_q <= d_ctl.degen;
			if (d_ctl.degen) begin
				axis_q <= tfn_pkg::AXIS_X;
				{ftx_q, fty_q, ftz_q, stx_q, sty_q, stz_q} <= '0;
			end else begin
				axis_q <= d_ctl.axis;
				case (d_ctl.axis)
					tfn_pkg::AXIS_X: begin
						{ftx_q, fty_q, ftz_q} <= {W'(0), qa, qb};
						{stx_q, sty_q, stz_q} <= {nl, pa, pb};
					end
					tfn_pkg::AXIS_Y: begin
						{ftx_q, fty_q, ftz_q} <= {qa, W'(0), qb};
						{stx_q, sty_q, stz_q} <= {pa, nl, pb};
					end
					default: begin
						{ftx_q, fty_q, ftz_q} <= {qa, qb, W'(0)};
						{stx_q, sty_q, stz_q} <= {pa, pb, nl};
					end
				endcase
			end
		end
	end

	assign frame_valid = frame_valid_q;
	assign result_tag = tag_q;
	assign first_tangent_x = ftx_q;
	assign first_tangent_y = fty_q;
	assign first_tangent_z = ftz_q;
	assign second_tangent_x = stx_q;
	assign second_tangent_y = sty_q;
	assign second_tangent_z = stz_q;
	assign chosen_axis = axis_q;
	assign degenerate = degen_q;
endmodule

// File: rtl/tfn_front.sv
// Front end: magnitudes, squares and cross products, axis choice, numerators.
// Four register stages. Uses tfn_pkg.
`timescale 1ns / 1ps
module tfn_front #(
	parameter int W = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [tfn_pkg::TAG_W-1:0] tag,
	input  logic signed [W-1:0] nx,
	input  logic signed [W-1:0] ny,
	input  logic signed [W-1:0] nz,
	output logic out_valid,
	output logic [2*W:0] s_sel,
	output logic [2*W-1:0] num [4],
	output tfn_pkg::ctl_t ctl
);
	localparam int NW = 2*W + 1;
	localparam int FRAC = W - 2;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [tfn_pkg::TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	logic [W-1:0] mx_s1, my_s1, mz_s1, mx_s2, my_s2, mz_s2, mx_s3, my_s3, mz_s3;
	logic [2:0] sg_s1, sg_s2, sg_s3;
	logic [2*W-1:0] qx_s2, qy_s2, qz_s2, pxy_s2, pxz_s2, pyz_s2;
	logic [2*W-1:0] pxy_s3, pxz_s3, pyz_s3;
	logic [NW-1:0] sx_s3, sy_s3, sz_s3;
	logic [NW-1:0] s_s4;
	logic [2*W-1:0] num_s4 [4];
	tfn_pkg::ctl_t ctl_s4;

	tfn_pkg::axis_t ax;
	tfn_pkg::ctl_t ctl_d;
	logic [NW-1:0] s_d;
	logic [2*W-1:0] num_d [4];
	logic [2*W-1:0] fx, fy, fz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag;
			mx_s1 <= nx[W-1] ? (~nx + W'(1)) : nx;
			my_s1 <= ny[W-1] ? (~ny + W'(1)) : ny;
			mz_s1 <= nz[W-1] ? (~nz + W'(1)) : nz;
			sg_s1 <= {nz[W-1], ny[W-1], nx[W-1]};

			tag_s2 <= tag_s1;
			mx_s2 <= mx_s1;
			my_s2 <= my_s1;
			mz_s2 <= mz_s1;
			sg_s2 <= sg_s1;
			qx_s2 <= (2*W)'(mx_s1) * (2*W)'(mx_s1);
			qy_s2 <= (2*W)'(my_s1) * (2*W)'(my_s1);
			qz_s2 <= (2*W)'(mz_s1) * (2*W)'(mz_s1);
			pxy_s2 <= (2*W)'(mx_s1) * (2*W)'(my_s1);
			pxz_s2 <= (2*W)'(mx_s1) * (2*W)'(mz_s1);
			pyz_s2 <= (2*W)'(my_s1) * (2*W)'(mz_s1);

			tag_s3 <= tag_s2;
			mx_s3 <= mx_s2;
			my_s3 <= my_s2;
			mz_s3 <= mz_s2;
			sg_s3 <= sg_s2;
			pxy_s3 <= pxy_s2;
			pxz_s3 <= pxz_s2;
			pyz_s3 <= pyz_s2;
			sx_s3 <= NW'(qy_s2) + NW'(qz_s2);
			sy_s3 <= NW'(qx_s2) + NW'(qz_s2);
			sz_s3 <= NW'(qx_s2) + NW'(qy_s2);

			s_s4 <= s_d;
			num_s4 <= num_d;
			ctl_s4 <= ctl_d;
		end
	end

	// quotient numerators: magnitude scaled up by the fraction width
	assign fx = (2*W)'({mx_s3, FRAC'(0)});
	assign fy = (2*W)'({my_s3, FRAC'(0)});
	assign fz = (2*W)'({mz_s3, FRAC'(0)});

	always_comb begin
		if (sx_s3 >= sy_s3 && sx_s3 >= sz_s3) begin
			ax = tfn_pkg::AXIS_X;
		end else if (sy_s3 >= sx_s3 && sy_s3 >= sz_s3) begin
			ax = tfn_pkg::AXIS_Y;
		end else begin
			ax = tfn_pkg::AXIS_Z;
		end
		ctl_d.tag = tag_s3;
		ctl_d.axis = ax;
		ctl_d.degen = (sx_s3 == '0) && (sy_s3 == '0) && (sz_s3 == '0);
		case (ax)
			tfn_pkg::AXIS_X: begin
				s_d = sx_s3;
				num_d[0] = fz;
				num_d[1] = fy;
				num_d[2] = pxy_s3;
				num_d[3] = pxz_s3;
				ctl_d.neg = {sg_s3[0] ^ sg_s3[2], sg_s3[0] ^ sg_s3[1], ~sg_s3[1], sg_s3[2]};
			end
			tfn_pkg::AXIS_Y: begin
				s_d = sy_s3;
				num_d[0] = fz;
				num_d[1] = fx;
				num_d[2] = pxy_s3;
				num_d[3] = pyz_s3;
				ctl_d.neg = {sg_s3[1] ^ sg_s3[2], sg_s3[0] ^ sg_s3[1], sg_s3[0], ~sg_s3[2]};
			end
			default: begin
				s_d = sz_s3;
				num_d[0] = fy;
				num_d[1] = fx;
				num_d[2] = pxz_s3;
				num_d[3] = pyz_s3;
				ctl_d.neg = {sg_s3[1] ^ sg_s3[2], sg_s3[0] ^ sg_s3[2], ~sg_s3[0], sg_s3[1]};
			end
		endcase
	end

	assign out_valid = v_s4;
	assign s_sel = s_s4;
	assign num = num_s4;
	assign ctl = ctl_s4;
endmodule

// File: rtl/tfn_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries an opaque sideband along with each request. No dependencies.
`timescale 1ns / 1ps
module tfn_sqrt #(
	parameter int W = 16,
	parameter int SB = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2*W:0] s,
	input  logic [SB-1:0] sb_in,
	output logic out_valid,
	output logic [W-1:0] root,
	output logic [SB-1:0] sb_out
);
	localparam int NW = 2*W + 1;

	logic v_s [W+1];
	logic [NW-1:0] rem_s [W+1];
	logic [W-1:0] root_s [W+1];
	logic [SB-1:0] sb_s [W+1];

	assign v_s[0] = in_valid;
	assign rem_s[0] = s;
	assign root_s[0] = '0;
	assign sb_s[0] = sb_in;

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int B = W - 1 - i;
		logic [NW-1:0] trial;
		logic ge;

		// (r + 2^B)^2 - r^2
		assign trial = (NW'(root_s[i]) << (B + 1)) + (NW'(1) << (2 * B));
		assign ge = rem_s[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? (rem_s[i] - trial) : rem_s[i];
				root_s[i+1] <= ge ? (root_s[i] | (W'(1) << B)) : root_s[i];
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	assign out_valid = v_s[W];
	assign root = root_s[W];
	assign sb_out = sb_s[W];
endmodule

// File: rtl/tfn_div.sv
// Four-lane pipelined restoring divider with round-to-nearest and overflow flag.
// One quotient bit per stage; carries the divisor and a sideband. No dependencies.
`timescale 1ns / 1ps
module tfn_div #(
	parameter int W = 16,
	parameter int SB = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2*W-1:0] num [4],
	input  logic [W-1:0] l_in,
	input  logic [SB-1:0] sb_in,
	output logic out_valid,
	output logic [3:0] ovf,
	output logic [W-1:0] q [4],
	output logic [W-1:0] l_out,
	output logic [SB-1:0] sb_out
);
	localparam int NW = 2*W + 1;

	logic v_a;
	logic [NW-1:0] numr_a [4];
	logic [W-1:0] l_a;
	logic [SB-1:0] sb_a;

	logic v_s [W+1];
	logic [NW-1:0] rem_s [W+1][4];
	logic [W-1:0] q_s [W+1][4];
	logic [3:0] ovf_s [W+1];
	logic [W-1:0] l_s [W+1];
	logic [SB-1:0] sb_s [W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_a <= in_valid;
			v_s[0] <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				numr_a[k] <= NW'(num[k]) + NW'(l_in >> 1);
				rem_s[0][k] <= numr_a[k];
				// quotient of 2^W or more saturates anyway
				ovf_s[0][k] <= numr_a[k] >= NW'({l_a, W'(0)});
			end
			l_a <= l_in;
			sb_a <= sb_in;
			l_s[0] <= l_a;
			sb_s[0] <= sb_a;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_q0
		assign q_s[0][k] = '0;
	end

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int B = W - 1 - i;
		logic [NW-1:0] dl;

		assign dl = NW'(l_s[i]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 4; k++) begin
					if (rem_s[i][k] >= dl) begin
						rem_s[i+1][k] <= rem_s[i][k] - dl;
						q_s[i+1][k] <= q_s[i][k] | (W'(1) << B);
					end else begin
						rem_s[i+1][k] <= rem_s[i][k];
						q_s[i+1][k] <= q_s[i][k];
					end
				end
				ovf_s[i+1] <= ovf_s[i];
				l_s[i+1] <= l_s[i];
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	assign out_valid = v_s[W];
	assign ovf = ovf_s[W];
	assign q = q_s[W];
	assign l_out = l_s[W];
	assign sb_out = sb_s[W];
endmodule

// File: rtl/tfn_check.sv
// Port-level checks for tangent_frame_from_normal, attached by bind.
// Uses tfn_pkg.
`timescale 1ns / 1ps
module tfn_check #(
	parameter int COMPONENT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic node_valid,
	input logic node_stall,
	input logic frame_valid,
	input logic frame_stall,
	input logic [tfn_pkg::TAG_W-1:0] result_tag,
	input logic signed [COMPONENT_WIDTH-1:0] first_tangent_x,
	input logic signed [COMPONENT_WIDTH-1:0] first_tangent_y,
	input logic signed [COMPONENT_WIDTH-1:0] first_tangent_z,
	input logic signed [COMPONENT_WIDTH-1:0] second_tangent_x,
	input logic signed [COMPONENT_WIDTH-1:0] second_tangent_y,
	input logic signed [COMPONENT_WIDTH-1:0] second_tangent_z,
	input logic [1:0] chosen_axis,
	input logic degenerate
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> frame_valid && $stable(result_tag)
			&& $stable(first_tangent_y))
		else $error("stalled result changed");

	// backpressure only comes from a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		node_stall |-> frame_valid && frame_stall)
		else $error("input stalled without output stall");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && degenerate |-> chosen_axis == tfn_pkg::AXIS_X
			&& first_tangent_x == '0 && first_tangent_y == '0 && first_tangent_z == '0
			&& second_tangent_x == '0 && second_tangent_y == '0 && second_tangent_z == '0)
		else $error("zero normal gave nonzero frame");

	// first tangent is orthogonal to the chosen axis
	a_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> (chosen_axis == tfn_pkg::AXIS_X && first_tangent_x == '0)
			|| (chosen_axis == tfn_pkg::AXIS_Y && first_tangent_y == '0)
			|| (chosen_axis == tfn_pkg::AXIS_Z && first_tangent_z == '0))
		else $error("bad axis or tangent along axis");
endmodule

bind tangent_frame_from_normal tfn_check #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_tfn_check (.*);

// File: tb/sv/tb.sv
// Testbench for tangent_frame_from_normal: random and corner normals, checked against
// a behavioral predictor held in a small scoreboard class. Depends on tfn_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
	localparam int CW = 16;
	localparam int FRAC = CW - 2;
	localparam int LATENCY = 2 * CW + 7;
	localparam int N_DIRECTED = 22;
	localparam int N_RANDOM = 1450;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [tfn_pkg::TAG_W-1:0] tag;
		logic signed [CW-1:0] t1x, t1y, t1z, t2x, t2y, t2z;
		tfn_pkg::axis_t axis;
		logic degen;
	} frame_t;

	class frame_board;
		frame_t pending[$];
		int fails;

		function logic [CW-1:0] sat(bit neg, longint unsigned mag);
			longint unsigned half;
			half = 64'd1 << (CW - 1);
			if (neg) begin
				if (mag > half) mag = half;
				return CW'(-mag);
			end
			if (mag > half - 1) mag = half - 1;
			return CW'(mag);
		endfunction

		function longint unsigned root_floor(longint unsigned s);
			longint unsigned r;
			r = 0;
			for (int b = 31; b >= 0; b--) begin
				longint unsigned c;
				c = r | (64'd1 << b);
				if (c * c <= s) r = c;
			end
			return r;
		endfunction

		function longint unsigned rdiv(longint unsigned num, longint unsigned len);
			return (num + (len >> 1)) / len;
		endfunction

		function logic [CW-1:0] quot(bit neg, longint unsigned m, longint unsigned len);
			return sat(neg, rdiv(m << FRAC, len));
		endfunction

		function logic [CW-1:0] pquot(bit na, longint unsigned ma, bit nb,
				longint unsigned mb, longint unsigned len);
			return sat(na != nb, rdiv(ma * mb, len));
		endfunction

		function void note_node(logic [tfn_pkg::TAG_W-1:0] tag, logic signed [CW-1:0] x,
				logic signed [CW-1:0] y, logic signed [CW-1:0] z);
			frame_t f;
			bit gx, gy, gz;
			longint unsigned mx, my, mz, sx, sy, sz, len;
			gx = x[CW-1]; gy = y[CW-1]; gz = z[CW-1];
			mx = gx ? longint'(-longint'(x)) : longint'(x);
			my = gy ? longint'(-longint'(y)) : longint'(y);
			mz = gz ? longint'(-longint'(z)) : longint'(z);
			sx = my * my + mz * mz;
			sy = mx * mx + mz * mz;
			sz = mx * mx + my * my;
			f = '{tag: tag, t1x: 0, t1y: 0, t1z: 0, t2x: 0, t2y: 0, t2z: 0,
				axis: tfn_pkg::AXIS_X, degen: 1'b0};
			if (sx == 0 && sy == 0 && sz == 0) begin
				f.degen = 1'b1;
			end else if (sx >= sy && sx >= sz) begin
				len = root_floor(sx);
				f.t1y = quot(gz, mz, len);
				f.t1z = quot(!gy, my, len);
				f.t2x = sat(1, len);
				f.t2y = pquot(gx, mx, gy, my, len);
				f.t2z = pquot(gx, mx, gz, mz, len);
			end else if (sy >= sx && sy >= sz) begin
				len = root_floor(sy);
				f.axis = tfn_pkg::AXIS_Y;
				f.t1x = quot(!gz, mz, len);
				f.t1z = quot(gx, mx, len);
				f.t2x = pquot(gx, mx, gy, my, len);
				f.t2y = sat(1, len);
				f.t2z = pquot(gy, my, gz, mz, len);
			end else begin
				len = root_floor(sz);
				f.axis = tfn_pkg::AXIS_Z;
				f.t1x = quot(gy, my, len);
				f.t1y = quot(!gx, mx, len);
				f.t2x = pquot(gx, mx, gz, mz, len);
				f.t2y = pquot(gy, my, gz, mz, len);
				f.t2z = sat(1, len);
			end
			pending.push_back(f);
		endfunction

		function void cmp(string name, longint e, longint a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				fails++;
			end
		endfunction

		function void check_frame(frame_t g);
			frame_t e;
			if (pending.size() == 0) begin
				$error("frame with tag %0d arrived with none expected", g.tag);
				fails++;
				return;
			end
			e = pending.pop_front();
			cmp("result_tag", e.tag, g.tag);
			cmp("first_tangent_x", e.t1x, g.t1x);
			cmp("first_tangent_y", e.t1y, g.t1y);
			cmp("first_tangent_z", e.t1z, g.t1z);
			cmp("second_tangent_x", e.t2x, g.t2x);
			cmp("second_tangent_y", e.t2y, g.t2y);
			cmp("second_tangent_z", e.t2z, g.t2z);
			cmp("chosen_axis", e.axis, g.axis);
			cmp("degenerate", e.degen, g.degen);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic node_valid = 1'b0;
	logic node_stall;
	logic [tfn_pkg::TAG_W-1:0] node_tag = '0;
	logic signed [CW-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic frame_valid;
	logic frame_stall = 1'b0;
	logic [tfn_pkg::TAG_W-1:0] result_tag;
	logic signed [CW-1:0] first_tangent_x, first_tangent_y, first_tangent_z;
	logic signed [CW-1:0] second_tangent_x, second_tangent_y, second_tangent_z;
	logic [1:0] chosen_axis;
	logic degenerate;

	frame_board board = new();
	longint cycles = 0;
	bit calm = 0;      // no idling in the last part of the run
	bit hold_done = 0;

	tangent_frame_from_normal #(.COMPONENT_WIDTH(CW)) uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// accepted requests feed the predictor; accepted frames are checked
	always @(posedge clk) begin
		if (arst_n && node_valid && !node_stall)
			board.note_node(node_tag, normal_x, normal_y, normal_z);
		if (arst_n && frame_valid && !frame_stall)
			board.check_frame('{tag: result_tag, t1x: first_tangent_x,
				t1y: first_tangent_y, t1z: first_tangent_z, t2x: second_tangent_x,
				t2y: second_tangent_y, t2z: second_tangent_z,
				axis: tfn_pkg::axis_t'(chosen_axis), degen: degenerate});
	end

	// receiver: random stall bursts, one long hold-off to fill the pipeline
	initial begin
		@(posedge arst_n);
		repeat (200) @(negedge clk);
		frame_stall <= 1'b1;
		repeat (150) @(negedge clk);
		frame_stall <= 1'b0;
		hold_done = 1;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				frame_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			frame_stall <= 1'b0;
		end
	end

	task automatic send_node(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic signed [CW-1:0] z);
		if (!calm && $urandom_range(0, 4) == 0) begin
			node_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		node_valid <= 1'b1;
		node_tag <= tfn_pkg::TAG_W'($urandom);
		normal_x <= x;
		normal_y <= y;
		normal_z <= z;
		do @(posedge clk); while (node_stall);
		@(negedge clk);
	endtask

	function automatic logic signed [CW-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return CW'($urandom);
			1: return CW'(int'($urandom_range(0, 32768)) - 16384);  // about unit length
			2: return CW'(int'($urandom_range(0, 64)) - 32);
			3: return {1'b1, {(CW-1){1'b0}}};
			4: return 0;
			default: return CW'(int'($urandom_range(0, 2 ** FRAC)) -
				(2 ** (FRAC - 1)));
		endcase
	endfunction

	localparam logic signed [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MAXN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE = CW'(1 << FRAC);

	initial begin
		logic signed [CW-1:0] dir[N_DIRECTED][3];
		dir = '{'{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE},
			'{-ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, -ONE}, '{MAXP, MAXP, MAXP},
			'{MAXN, MAXN, MAXN}, '{MAXN, MAXP, 0}, '{1, 0, 0}, '{0, 0, -1},
			'{1, 1, 1}, '{ONE, ONE, 0}, '{0, ONE, ONE}, '{ONE, 0, ONE},
			'{MAXP, 1, MAXN}, '{-1, -1, -1}, '{11585, 11585, 0},
			'{9459, 9459, 9459}, '{0, MAXN, 1}, '{3, -7, 2}};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir[i]) send_node(dir[i][0], dir[i][1], dir[i][2]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 150) begin
				wait (hold_done);
				calm = 1;
			end
			send_node(rand_comp(), rand_comp(), rand_comp());
		end
		node_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (board.fails == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
